[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/nas_pkg.sv]
`timescale 1ns / 1ps
package nas_pkg;

    localparam int ARG_W = 13;
    localparam int CHAR_W = 8;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [ARG_W-1:0] ARGNUM_MAX = 13'd8191;
    localparam logic [ARG_W-1:0] ARGNUM_ONE = 13'd1;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    localparam logic [CHAR_W-1:0] RST_DELIM  = 8'd44;
    localparam logic [CHAR_W-1:0] RST_QUOTE  = 8'd34;
    localparam logic [CHAR_W-1:0] RST_ESCAPE = 8'd92;

    // Register indexes on the APB port (byte address = 4 * index).
    localparam logic [1:0] REG_DELIM  = 2'd0;
    localparam logic [1:0] REG_QUOTE  = 2'd1;
    localparam logic [1:0] REG_ESCAPE = 2'd2;

    // Result queue: two pushes and one pop per cycle.
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;
    localparam logic [QCNT_W-1:0] QROOM2 = 3'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] delim;
        logic [CHAR_W-1:0] quote;
        logic [CHAR_W-1:0] escape;
    } t_cfg;

    typedef struct packed {
        logic [ARG_W-1:0]        index;
        logic signed [ARG_W-1:0] start;
        logic signed [ARG_W-1:0] fin;
        logic                    present;
        logic                    done;
        logic [ARG_W-1:0]        total;
    } t_result;

    // Up to two results per character: a closed argument, then the final one.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

[rtl/nas_if.sv]
`timescale 1ns / 1ps
interface nas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface nas_out_if;
    logic               valid;
    logic               ready;
    logic [12:0]        arg_index;
    logic signed [12:0] arg_start;
    logic signed [12:0] arg_end;
    logic               arg_present;
    logic               string_done;
    logic [12:0]        arg_total;

    modport source (output valid, output arg_index, output arg_start, output arg_end,
                    output arg_present, output string_done, output arg_total,
                    input ready);
    modport sink (input valid, input arg_index, input arg_start, input arg_end,
                  input arg_present, input string_done, input arg_total,
                  output ready);
endinterface

[rtl/nas_cfg.sv]
`timescale 1ns / 1ps
module nas_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nas_pkg::APB_AW-1:0]  paddr,
    input  logic [nas_pkg::APB_DW-1:0]  pwdata,
    output logic [nas_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output nas_pkg::t_cfg               o_cfg
);

    nas_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim  <= nas_pkg::RST_DELIM;
            r_cfg.quote  <= nas_pkg::RST_QUOTE;
            r_cfg.escape <= nas_pkg::RST_ESCAPE;
        end else if (wr_en) begin
            case (reg_idx)
                nas_pkg::REG_DELIM:  r_cfg.delim  <= pwdata[7:0];
                nas_pkg::REG_QUOTE:  r_cfg.quote  <= pwdata[7:0];
                nas_pkg::REG_ESCAPE: r_cfg.escape <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nas_pkg::REG_DELIM:  prdata = {24'd0, r_cfg.delim};
            nas_pkg::REG_QUOTE:  prdata = {24'd0, r_cfg.quote};
            nas_pkg::REG_ESCAPE: prdata = {24'd0, r_cfg.escape};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/nas_scan.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nas_scan #(
    parameter int MAX_STRING_LENGTH = 4096,
    parameter int DEPTH_BITS        = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [nas_pkg::CHAR_W-1:0]   i_char,
    input  logic                         i_last,
    input  nas_pkg::t_cfg                i_cfg,
    output nas_pkg::t_push               o_push
);

    localparam int POS_W = $clog2(MAX_STRING_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_STRING_LENGTH - 1);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_HI = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_LO = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [nas_pkg::ARG_W-1:0] MINUS_ONE = '1;

    logic [POS_W-1:0]                   r_pos, n_pos;
    logic                               r_in_arg, n_in_arg;
    logic signed [DEPTH_BITS-1:0]       r_depth, n_depth;
    logic                               r_quotes, n_quotes;
    logic [nas_pkg::ARG_W-1:0]          r_argn, n_argn;
    logic signed [nas_pkg::ARG_W-1:0]   r_start, n_start;
    logic                               r_lns_ok, n_lns_ok;
    logic signed [nas_pkg::ARG_W-1:0]   r_lns, n_lns;
    logic [nas_pkg::CHAR_W-1:0]         r_prev, n_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_in_arg <= 1'b0;
            r_depth  <= '0;
            r_quotes <= 1'b0;
            r_argn   <= nas_pkg::ARGNUM_ONE;
            r_start  <= MINUS_ONE;
            r_lns_ok <= 1'b0;
            r_lns    <= MINUS_ONE;
            r_prev   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_in_arg <= n_in_arg;
            r_depth  <= n_depth;
            r_quotes <= n_quotes;
            r_argn   <= n_argn;
            r_start  <= n_start;
            r_lns_ok <= n_lns_ok;
            r_lns    <= n_lns;
            r_prev   <= n_prev;
        end
    end

    always_comb begin
        logic                             is_space;
        logic                             is_open;
        logic                             is_close;
        logic                             closed;
        logic signed [nas_pkg::ARG_W-1:0] pos13;

        is_space = (i_char == nas_pkg::CH_SPACE);
        is_open  = (i_char == nas_pkg::CH_LPAREN) || (i_char == nas_pkg::CH_LBRACK) ||
                   (i_char == nas_pkg::CH_LBRACE);
        is_close = (i_char == nas_pkg::CH_RPAREN) || (i_char == nas_pkg::CH_RBRACK) ||
                   (i_char == nas_pkg::CH_RBRACE);
        pos13    = nas_pkg::ARG_W'(r_pos);
        closed   = 1'b0;

        n_pos    = r_pos;
        n_in_arg = r_in_arg;
        n_depth  = r_depth;
        n_quotes = r_quotes;
        n_argn   = r_argn;
        n_start  = r_start;
        n_lns_ok = r_lns_ok;
        n_lns    = r_lns;
        n_prev   = r_prev;
        o_push   = '0;

        if (i_accept) begin
            // open an argument on the first non-space character
            if (!r_in_arg && !is_space) begin
                n_in_arg = 1'b1;
                n_start  = pos13;
                n_lns_ok = 1'b0;
            end

            if (n_in_arg) begin
                if (i_char != i_cfg.delim) begin
                    if (!r_quotes && is_open) begin
                        if (r_depth != DEPTH_HI) n_depth = r_depth + 1'b1;
                    end else if (!r_quotes && is_close) begin
                        if (r_depth != DEPTH_LO) n_depth = r_depth - 1'b1;
                    end else if (i_char == i_cfg.quote &&
                                 !(r_pos != '0 && r_prev == i_cfg.escape)) begin
                        n_quotes = !r_quotes;
                    end
                end else if (r_depth == '0 && !r_quotes) begin
                    o_push.v0            = 1'b1;
                    o_push.r0.index      = r_argn;
                    o_push.r0.start      = n_start;
                    o_push.r0.fin        = n_lns_ok ? n_lns : n_start - 1'b1;
                    o_push.r0.present    = 1'b1;
                    o_push.r0.done       = 1'b0;
                    o_push.r0.total      = '0;
                    if (r_argn != nas_pkg::ARGNUM_MAX) n_argn = r_argn + 1'b1;
                    n_in_arg = 1'b0;
                    n_start  = MINUS_ONE;
                    n_lns_ok = 1'b0;
                    closed   = 1'b1;
                end
                if (!closed && !is_space) begin
                    n_lns_ok = 1'b1;
                    n_lns    = pos13;
                end
            end

            if (i_last) begin
                o_push.v1         = 1'b1;
                o_push.r1.index   = n_argn;
                o_push.r1.done    = 1'b1;
                o_push.r1.total   = n_argn;
                if (n_in_arg) begin
                    o_push.r1.start   = n_start;
                    o_push.r1.fin     = n_lns_ok ? n_lns : n_start - 1'b1;
                    o_push.r1.present = 1'b1;
                end else begin
                    o_push.r1.start   = MINUS_ONE;
                    o_push.r1.fin     = MINUS_ONE;
                    o_push.r1.present = 1'b0;
                end
                // drop all per-string state
                n_pos    = '0;
                n_in_arg = 1'b0;
                n_depth  = '0;
                n_quotes = 1'b0;
                n_argn   = nas_pkg::ARGNUM_ONE;
                n_start  = MINUS_ONE;
                n_lns_ok = 1'b0;
                n_lns    = MINUS_ONE;
                n_prev   = '0;
            end else begin
                n_prev = i_char;
                n_pos  = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last,
                 r_pos == '0 && r_argn == nas_pkg::ARGNUM_ONE && !r_in_arg && r_depth == '0)
    `ASSERT_NEXT(a_close_leaves_arg, i_clk, i_rst_n, o_push.v0 && !i_last,
                 !r_in_arg && r_start == MINUS_ONE)
    `ASSERT_IMPL(a_close_needs_level, i_clk, i_rst_n, o_push.v0,
                 r_depth == '0 && !r_quotes && i_char == i_cfg.delim)

endmodule

[rtl/nas_outq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nas_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nas_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output nas_pkg::t_result  o_head
);

    nas_pkg::t_result                r_mem [nas_pkg::QDEPTH];
    logic [nas_pkg::QIDX_W-1:0]      r_wp, n_wp;
    logic [nas_pkg::QIDX_W-1:0]      r_rp, n_rp;
    logic [nas_pkg::QCNT_W-1:0]      r_count, n_count;
    logic [nas_pkg::QIDX_W-1:0]      wp1;
    logic                            pop_en;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= nas_pkg::QROOM2);
    assign o_head  = r_mem[r_rp];
    assign pop_en  = i_pop && o_valid;
    assign wp1     = r_wp + nas_pkg::QIDX_W'(i_push.v0);

    always_comb begin
        n_wp    = r_wp + nas_pkg::QIDX_W'(i_push.v0) + nas_pkg::QIDX_W'(i_push.v1);
        n_rp    = r_rp + nas_pkg::QIDX_W'(pop_en);
        n_count = r_count + nas_pkg::QCNT_W'(i_push.v0) + nas_pkg::QCNT_W'(i_push.v1)
                  - nas_pkg::QCNT_W'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wp] <= i_push.r0;
        if (i_push.v1) r_mem[wp1]  <= i_push.r1;
    end

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
                 r_count <= nas_pkg::QCNT_W'(nas_pkg::QDEPTH))
    `ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push.v0 || i_push.v1, o_room)
    `ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop_en && !i_push.v0 && !i_push.v1,
                 r_count == $past(r_count) - 1'b1)

endmodule

[rtl/nested_argument_splitter_unit.sv]
`timescale 1ns / 1ps
// Nested argument splitter: scans a string one character word at a time and
// reports each argument (index, start, end, present flag) as an output word.
// Input channel i_in carries char_code and last_char; output channel o_out
// carries one argument word. A delimiter closes an argument only at bracket
// depth zero and outside quotes. The character flagged last_char yields the
// final argument word with string_done and arg_total set.
// Result words for an accepted character are registered in the result queue
// and reach o_out in the next cycle when the queue is empty.
// Throughput: one character per cycle. Each character yields zero, one or
// two argument words; a four-entry result queue takes two and gives one per
// cycle, and i_in.ready drops while fewer than two entries are free.
// Receiver stall: words wait in the queue; once it holds three the input stalls.
// Reset (i_rst_n low, synchronous): the queue empties, scan state returns to
// position zero / argument one, and the registers take delimiter 44, quote
// 34, escape 92. Registers sit on the APB port at byte addresses 0, 4, 8 and
// are to be written by the user only while the block is idle; the block does not enforce this.
module nested_argument_splitter_unit #(
    parameter int MAX_STRING_LENGTH = 4096,
    parameter int DEPTH_BITS        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    nas_in_if.sink                      i_in,
    nas_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nas_pkg::APB_AW-1:0]  paddr,
    input  logic [nas_pkg::APB_DW-1:0]  pwdata,
    output logic [nas_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    nas_pkg::t_cfg    cfg;
    nas_pkg::t_push   push;
    nas_pkg::t_result head;
    logic             room;
    logic             accept;

    // hold input while the queue cannot take two words
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    nas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nas_scan #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
        .DEPTH_BITS        (DEPTH_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_code),
        .i_last   (i_in.last_char),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    nas_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    // advance the queue head onto the output channel
    assign o_out.arg_index   = head.index;
    assign o_out.arg_start   = head.start;
    assign o_out.arg_end     = head.fin;
    assign o_out.arg_present = head.present;
    assign o_out.string_done = head.done;
    assign o_out.arg_total   = head.total;

endmodule
